// ----- design/tcl_pkg.sv -----
package tcl_pkg;

  localparam int CW         = 32;
  localparam int FRAC       = 16;
  localparam int NB         = 30;
  localparam int WW         = FRAC + 1;
  localparam int ONE        = 1 << FRAC;
  localparam int SQW        = 2 * NB + 2;
  localparam int RW         = NB + 1;
  localparam int QW         = FRAC + 1;
  localparam int NUMW       = NB + FRAC;
  localparam int SQRT_STEPS = RW;
  localparam int DIV_STEPS  = QW;
  localparam int BLW        = $clog2(CW + 1);

  localparam logic ACT_VEC  = 1'b0;
  localparam logic ACT_QUAT = 1'b1;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic [NB-1:0] nmag_t;

  typedef struct packed {
    logic            action;
    logic            zero;
    logic [3:0]      neg;
    comp_t [2:0]     vec;
    nmag_t [3:0]     mag;
  } pay_t;

endpackage

// ----- design/tcl_lerp.sv -----
module tcl_lerp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic                             in_act,
  input  tcl_pkg::comp_t [3:0]             from_c,
  input  tcl_pkg::comp_t [3:0]             to_c,
  input  logic [tcl_pkg::WW-1:0]           blend,
  output logic                             out_vld,
  output logic                             out_act,
  output tcl_pkg::comp_t [3:0]             q
);

  localparam int DW = tcl_pkg::CW + 1;
  localparam int PW = DW + tcl_pkg::WW + 1;

  logic [2:0]                 vld_r;
  logic [2:0]                 act_r;
  logic [tcl_pkg::WW-1:0]     w_r;
  logic [tcl_pkg::WW-1:0]     blend_c;
  logic signed [DW-1:0]       diff_r [4];
  tcl_pkg::comp_t             from1_r [4];
  tcl_pkg::comp_t             from2_r [4];
  logic signed [PW-1:0]       prod_r [4];
  logic signed [PW-1:0]       sum_c [4];
  tcl_pkg::comp_t             sat_c [4];
  tcl_pkg::comp_t             q_r [4];

  assign blend_c = (blend > tcl_pkg::WW'(tcl_pkg::ONE)) ? tcl_pkg::WW'(tcl_pkg::ONE) : blend;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_c[i] = PW'(from2_r[i]) + (prod_r[i] >>> tcl_pkg::FRAC);
      if ((&sum_c[i][PW-1:tcl_pkg::CW-1]) || !(|sum_c[i][PW-1:tcl_pkg::CW-1])) begin
        sat_c[i] = sum_c[i][tcl_pkg::CW-1:0];
      end else if (sum_c[i][PW-1]) begin
        sat_c[i] = {1'b1, {(tcl_pkg::CW-1){1'b0}}};
      end else begin
        sat_c[i] = {1'b0, {(tcl_pkg::CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    act_r <= {act_r[1:0], in_act};
    w_r   <= blend_c;
    for (int i = 0; i < 4; i++) begin
      diff_r[i]  <= DW'(to_c[i]) - DW'(from_c[i]);
      from1_r[i] <= from_c[i];
      prod_r[i]  <= PW'(diff_r[i]) * PW'($signed({1'b0, w_r}));
      from2_r[i] <= from1_r[i];
      q_r[i]     <= sat_c[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q[i] = q_r[i];
    end
  end

  assign out_vld = vld_r[2];
  assign out_act = act_r[2];

endmodule

// ----- design/tcl_scale.sv -----
module tcl_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic                        in_act,
  input  tcl_pkg::comp_t [3:0]        q,
  output logic                        out_vld,
  output tcl_pkg::pay_t               pay,
  output logic [tcl_pkg::SQW-1:0]     ssum
);

  localparam int CW = tcl_pkg::CW;
  localparam int NB = tcl_pkg::NB;

  logic [6:0]              vld_r;

  logic [CW-1:0]           mag_c [4];
  logic [CW-1:0]           mag_a_r [4];
  logic [CW-1:0]           mx_a_r [2];
  logic [3:0]              neg_a_r;
  logic                    act_a_r;
  tcl_pkg::comp_t [2:0]    vec_a_r;

  logic [CW-1:0]           m_b_r;
  logic [CW-1:0]           mag_b_r [4];
  logic [3:0]              neg_b_r;
  logic                    act_b_r;
  tcl_pkg::comp_t [2:0]    vec_b_r;

  logic [tcl_pkg::BLW-1:0] bl_c;
  logic [CW-1:0]           mag_c_r [4];
  logic                    dir_c_r;
  logic [tcl_pkg::BLW-1:0] amt_c_r;
  logic                    zero_c_r;
  logic [3:0]              neg_c_r;
  logic                    act_c_r;
  tcl_pkg::comp_t [2:0]    vec_c_r;

  tcl_pkg::pay_t           pay_d_r;
  tcl_pkg::pay_t           pay_e_r;
  tcl_pkg::pay_t           pay_f_r;
  tcl_pkg::pay_t           pay_g_r;
  tcl_pkg::pay_t           pay_d_c;

  logic [2*NB-1:0]         sq_e_r [4];
  logic [2*NB:0]           s01_f_r;
  logic [2*NB:0]           s23_f_r;
  logic [tcl_pkg::SQW-1:0] sum_g_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_c[i] = q[i][CW-1] ? (~q[i]) + CW'(1) : q[i];
    end
  end

  always_comb begin
    bl_c = '0;
    for (int j = 0; j < CW; j++) begin
      if (m_b_r[j]) begin
        bl_c = tcl_pkg::BLW'(j + 1);
      end
    end
  end

  always_comb begin
    pay_d_c.action = act_c_r;
    pay_d_c.zero   = zero_c_r;
    pay_d_c.neg    = neg_c_r;
    pay_d_c.vec    = vec_c_r;
    for (int i = 0; i < 4; i++) begin
      pay_d_c.mag[i] = dir_c_r ? NB'(mag_c_r[i] >> amt_c_r) : NB'(mag_c_r[i] << amt_c_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      mag_a_r[i] <= mag_c[i];
      neg_a_r[i] <= q[i][CW-1];
    end
    mx_a_r[0] <= (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
    mx_a_r[1] <= (mag_c[2] > mag_c[3]) ? mag_c[2] : mag_c[3];
    act_a_r   <= in_act;
    vec_a_r   <= q[2:0];

    m_b_r   <= (mx_a_r[0] > mx_a_r[1]) ? mx_a_r[0] : mx_a_r[1];
    mag_b_r <= mag_a_r;
    neg_b_r <= neg_a_r;
    act_b_r <= act_a_r;
    vec_b_r <= vec_a_r;

    dir_c_r  <= bl_c > tcl_pkg::BLW'(NB);
    amt_c_r  <= (bl_c > tcl_pkg::BLW'(NB)) ? bl_c - tcl_pkg::BLW'(NB)
                                          : tcl_pkg::BLW'(NB) - bl_c;
    zero_c_r <= (m_b_r == '0);
    mag_c_r  <= mag_b_r;
    neg_c_r  <= neg_b_r;
    act_c_r  <= act_b_r;
    vec_c_r  <= vec_b_r;

    pay_d_r <= pay_d_c;

    for (int i = 0; i < 4; i++) begin
      sq_e_r[i] <= (2*NB)'(pay_d_r.mag[i]) * (2*NB)'(pay_d_r.mag[i]);
    end
    pay_e_r <= pay_d_r;

    s01_f_r <= (2*NB+1)'(sq_e_r[0]) + (2*NB+1)'(sq_e_r[1]);
    s23_f_r <= (2*NB+1)'(sq_e_r[2]) + (2*NB+1)'(sq_e_r[3]);
    pay_f_r <= pay_e_r;

    sum_g_r <= tcl_pkg::SQW'(s01_f_r) + tcl_pkg::SQW'(s23_f_r);
    pay_g_r <= pay_f_r;
  end

  assign out_vld = vld_r[6];
  assign pay     = pay_g_r;
  assign ssum    = sum_g_r;

endmodule

// ----- design/tcl_sqrt.sv -----
module tcl_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  tcl_pkg::pay_t               in_pay,
  input  logic [tcl_pkg::SQW-1:0]     s,
  output logic                        out_vld,
  output tcl_pkg::pay_t               out_pay,
  output logic [tcl_pkg::RW-1:0]      root
);

  localparam int N   = tcl_pkg::SQRT_STEPS;
  localparam int SQW = tcl_pkg::SQW;

  logic [SQW-1:0] rem_r [1:N];
  logic [SQW-1:0] res_r [1:N];
  tcl_pkg::pay_t  pay_r [1:N];
  logic           vld_r [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int BP = 2 * (N - 1 - k);
    localparam logic [SQW-1:0] BIT = {{(SQW-1){1'b0}}, 1'b1} << BP;

    logic [SQW-1:0] rem_i;
    logic [SQW-1:0] res_i;
    tcl_pkg::pay_t  pay_i;
    logic           vld_i;
    logic [SQW:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_i = s;
      assign res_i = '0;
      assign pay_i = in_pay;
      assign vld_i = in_vld;
    end else begin : g_next
      assign rem_i = rem_r[k];
      assign res_i = res_r[k];
      assign pay_i = pay_r[k];
      assign vld_i = vld_r[k];
    end

    assign trial = {1'b0, res_i} + {1'b0, BIT};
    assign ge    = {1'b0, rem_i} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? rem_i - trial[SQW-1:0] : rem_i;
      res_r[k+1] <= ge ? (res_i >> 1) + BIT : res_i >> 1;
      pay_r[k+1] <= pay_i;
    end
  end

  assign out_vld = vld_r[N];
  assign out_pay = pay_r[N];
  assign root    = res_r[N][tcl_pkg::RW-1:0];

endmodule

// ----- design/tcl_div.sv -----
module tcl_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  tcl_pkg::pay_t                    in_pay,
  input  logic [tcl_pkg::RW-1:0]           len,
  output logic                             out_vld,
  output tcl_pkg::pay_t                    out_pay,
  output logic [3:0][tcl_pkg::QW-1:0]      quo
);

  localparam int N    = tcl_pkg::DIV_STEPS;
  localparam int NUMW = tcl_pkg::NUMW;
  localparam int QW   = tcl_pkg::QW;

  logic [3:0][NUMW-1:0]     num_r [1:N];
  logic [3:0][QW-1:0]       quo_r [1:N];
  logic [tcl_pkg::RW-1:0]   len_r [1:N];
  tcl_pkg::pay_t            pay_r [1:N];
  logic                     vld_r [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int SH = N - 1 - k;

    logic [3:0][NUMW-1:0]   num_i;
    logic [3:0][QW-1:0]     quo_i;
    logic [tcl_pkg::RW-1:0] len_i;
    tcl_pkg::pay_t          pay_i;
    logic                   vld_i;
    logic [NUMW:0]          dvs;
    logic [3:0][NUMW-1:0]   num_n;
    logic [3:0][QW-1:0]     quo_n;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          num_i[l] = {in_pay.mag[l], {tcl_pkg::FRAC{1'b0}}};
        end
      end
      assign quo_i = '0;
      assign len_i = len;
      assign pay_i = in_pay;
      assign vld_i = in_vld;
    end else begin : g_next
      assign num_i = num_r[k];
      assign quo_i = quo_r[k];
      assign len_i = len_r[k];
      assign pay_i = pay_r[k];
      assign vld_i = vld_r[k];
    end

    assign dvs = (NUMW+1)'(len_i) << SH;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if ({1'b0, num_i[l]} >= dvs) begin
          num_n[l] = NUMW'({1'b0, num_i[l]} - dvs);
          quo_n[l] = {quo_i[l][QW-2:0], 1'b1};
        end else begin
          num_n[l] = num_i[l];
          quo_n[l] = {quo_i[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      num_r[k+1] <= num_n;
      quo_r[k+1] <= quo_n;
      len_r[k+1] <= len_i;
      pay_r[k+1] <= pay_i;
    end
  end

  assign out_vld = vld_r[N];
  assign out_pay = pay_r[N];
  assign quo     = quo_r[N];

endmodule

// ----- design/transform_component_lerp.sv -----
// Channel  | Handshake            | Ports
// ---------+----------------------+-----------------------------------------------
// Input    | start high, busy low | in_action, in_from_*, in_to_*, in_blend
// Result   | out_valid, one cycle | out_x, out_y, out_z, out_w, out_zero_length
//
// One item is taken in every cycle while busy is low.
// Items pass the lerp and scale stages, the pipelined square root (one root bit per stage,
// 31 stages) and the four-lane divider (one quotient bit per stage, 17 stages).
// Reset clears the valid bits of every stage; busy is high for one cycle after reset.
// Results cannot be held off by the receiver, so the pipeline never stalls.
module transform_component_lerp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_action,
  input  logic signed [tcl_pkg::CW-1:0] in_from_x,
  input  logic signed [tcl_pkg::CW-1:0] in_from_y,
  input  logic signed [tcl_pkg::CW-1:0] in_from_z,
  input  logic signed [tcl_pkg::CW-1:0] in_from_w,
  input  logic signed [tcl_pkg::CW-1:0] in_to_x,
  input  logic signed [tcl_pkg::CW-1:0] in_to_y,
  input  logic signed [tcl_pkg::CW-1:0] in_to_z,
  input  logic signed [tcl_pkg::CW-1:0] in_to_w,
  input  logic [tcl_pkg::WW-1:0]        in_blend,
  output logic                         out_valid,
  output logic signed [tcl_pkg::CW-1:0] out_x,
  output logic signed [tcl_pkg::CW-1:0] out_y,
  output logic signed [tcl_pkg::CW-1:0] out_z,
  output logic signed [tcl_pkg::CW-1:0] out_w,
  output logic                         out_zero_length
);

  localparam int CW = tcl_pkg::CW;

  logic                          busy_r;
  logic                          acc;
  tcl_pkg::comp_t [3:0]          from_c;
  tcl_pkg::comp_t [3:0]          to_c;

  logic                          l_vld;
  logic                          l_act;
  tcl_pkg::comp_t [3:0]          l_q;

  logic                          s_vld;
  tcl_pkg::pay_t                 s_pay;
  logic [tcl_pkg::SQW-1:0]       s_sum;

  logic                          r_vld;
  tcl_pkg::pay_t                 r_pay;
  logic [tcl_pkg::RW-1:0]        r_root;

  logic                          d_vld;
  tcl_pkg::pay_t                 d_pay;
  logic [3:0][tcl_pkg::QW-1:0]   d_quo;

  tcl_pkg::comp_t [3:0]          res_c;
  logic                          zl_c;
  tcl_pkg::comp_t                mag_q;

  logic                          valid_r;
  tcl_pkg::comp_t [3:0]          res_r;
  logic                          zl_r;

  assign acc    = start && !busy_r;
  assign from_c = {in_from_w, in_from_z, in_from_y, in_from_x};
  assign to_c   = {in_to_w, in_to_z, in_to_y, in_to_x};

  tcl_lerp u_lerp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .in_act  (in_action),
    .from_c  (from_c),
    .to_c    (to_c),
    .blend   (in_blend),
    .out_vld (l_vld),
    .out_act (l_act),
    .q       (l_q)
  );

  tcl_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (l_vld),
    .in_act  (l_act),
    .q       (l_q),
    .out_vld (s_vld),
    .pay     (s_pay),
    .ssum    (s_sum)
  );

  tcl_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s_vld),
    .in_pay  (s_pay),
    .s       (s_sum),
    .out_vld (r_vld),
    .out_pay (r_pay),
    .root    (r_root)
  );

  tcl_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (r_vld),
    .in_pay  (r_pay),
    .len     (r_root),
    .out_vld (d_vld),
    .out_pay (d_pay),
    .quo     (d_quo)
  );

  always_comb begin
    res_c = '0;
    zl_c  = 1'b0;
    mag_q = '0;
    if (d_pay.action == tcl_pkg::ACT_VEC) begin
      res_c[2:0] = d_pay.vec;
    end else if (d_pay.zero) begin
      zl_c = 1'b1;
    end else begin
      for (int l = 0; l < 4; l++) begin
        mag_q    = CW'(d_quo[l]);
        res_c[l] = d_pay.neg[l] ? -mag_q : mag_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_c;
    zl_r  <= zl_c;
  end

  assign busy            = busy_r;
  assign out_valid       = valid_r;
  assign out_x           = res_r[0];
  assign out_y           = res_r[1];
  assign out_z           = res_r[2];
  assign out_w           = res_r[3];
  assign out_zero_length = zl_r;

endmodule

// ----- design/tcl_chk.sv -----
module tcl_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          busy,
  input logic                          out_valid,
  input logic signed [tcl_pkg::CW-1:0] out_x,
  input logic signed [tcl_pkg::CW-1:0] out_y,
  input logic signed [tcl_pkg::CW-1:0] out_z,
  input logic signed [tcl_pkg::CW-1:0] out_w,
  input logic                          out_zero_length
);

  a_rst_busy : assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  a_rst_valid : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_ready : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

  a_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0)
    else $error("zero length item with non-zero components");

  a_wrange : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_w <= tcl_pkg::ONE && out_w >= -tcl_pkg::ONE)
    else $error("W component beyond unit length");

endmodule

bind transform_component_lerp tcl_chk u_tcl_chk (.*);

// ----- bench/transform_component_lerp_tb.sv -----
module transform_component_lerp_tb;

  typedef struct {
    logic                    action;
    logic [tcl_pkg::CW-1:0]  from_c [4];
    logic [tcl_pkg::CW-1:0]  to_c [4];
    logic [tcl_pkg::WW-1:0]  blend;
  } blend_item_t;

  typedef struct {
    logic [tcl_pkg::CW-1:0] comp [4];
    logic                   zero_length;
  } blend_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic                         in_action;
  logic signed [tcl_pkg::CW-1:0] in_from_x, in_from_y, in_from_z, in_from_w;
  logic signed [tcl_pkg::CW-1:0] in_to_x, in_to_y, in_to_z, in_to_w;
  logic [tcl_pkg::WW-1:0]       in_blend;
  logic                         out_valid;
  logic signed [tcl_pkg::CW-1:0] out_x, out_y, out_z, out_w;
  logic                         out_zero_length;

  blend_item_t   pending_items [$];
  blend_result_t expected_blends [$];
  int            idle_percent;
  int            error_count;
  bit            stimulus_done;

  transform_component_lerp i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_action(in_action),
    .in_from_x(in_from_x), .in_from_y(in_from_y), .in_from_z(in_from_z),
    .in_from_w(in_from_w), .in_to_x(in_to_x), .in_to_y(in_to_y), .in_to_z(in_to_z),
    .in_to_w(in_to_w), .in_blend(in_blend), .out_valid(out_valid), .out_x(out_x),
    .out_y(out_y), .out_z(out_z), .out_w(out_w), .out_zero_length(out_zero_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint sat_comp(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (tcl_pkg::CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint floor_lerp(longint a, longint b, longint wt);
    longint diff;
    longint prod;
    longint q;
    diff = b - a;
    prod = diff * wt;
    q = prod >>> tcl_pkg::FRAC;
    return sat_comp(a + q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic blend_result_t predict_blend(blend_item_t it);
    blend_result_t r;
    longint q [4];
    longint unsigned mag [4];
    longint unsigned m, s, len;
    longint wt;
    longint rq;
    int bl;
    wt = (it.blend > tcl_pkg::ONE) ? tcl_pkg::ONE : it.blend;
    for (int i = 0; i < 4; i++)
      q[i] = floor_lerp(longint'($signed(it.from_c[i])), longint'($signed(it.to_c[i])), wt);
    r.zero_length = 1'b0;
    for (int i = 0; i < 4; i++) r.comp[i] = '0;
    if (it.action == tcl_pkg::ACT_VEC) begin
      for (int i = 0; i < 3; i++) r.comp[i] = q[i][tcl_pkg::CW-1:0];
      return r;
    end
    m = 0;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (q[i] < 0) ? -q[i] : q[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      r.zero_length = 1'b1;
      return r;
    end
    bl = 0;
    while (bl < 64 && (m >> bl) != 0) bl++;
    for (int i = 0; i < 4; i++) begin
      if (bl > tcl_pkg::NB) mag[i] >>= (bl - tcl_pkg::NB);
      else mag[i] <<= (tcl_pkg::NB - bl);
      s += mag[i] * mag[i];
    end
    len = int_sqrt(s);
    for (int i = 0; i < 4; i++) begin
      rq = longint'((mag[i] << tcl_pkg::FRAC) / len);
      if (q[i] < 0) rq = -rq;
      r.comp[i] = rq[tcl_pkg::CW-1:0];
    end
    return r;
  endfunction

  function automatic logic [tcl_pkg::CW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 131072) - 65536;
      3: return 32'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [tcl_pkg::WW-1:0] rand_blend();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return tcl_pkg::WW'(tcl_pkg::ONE);
      2: return tcl_pkg::WW'($urandom_range(tcl_pkg::ONE + 1, (1 << tcl_pkg::WW) - 1));
      default: return tcl_pkg::WW'($urandom_range(0, tcl_pkg::ONE));
    endcase
  endfunction

  task automatic queue_item(logic act, logic [tcl_pkg::CW-1:0] f [4],
                            logic [tcl_pkg::CW-1:0] t [4], logic [tcl_pkg::WW-1:0] b);
    blend_item_t it;
    it.action = act;
    it.from_c = f;
    it.to_c = t;
    it.blend = b;
    pending_items.push_back(it);
  endtask

  task automatic queue_random(int count);
    logic [tcl_pkg::CW-1:0] f [4];
    logic [tcl_pkg::CW-1:0] t [4];
    logic act;
    for (int n = 0; n < count; n++) begin
      act = 1'($urandom_range(0, 1));
      for (int i = 0; i < 4; i++) begin
        f[i] = rand_comp();
        t[i] = ($urandom_range(0, 9) == 0) ? f[i] : rand_comp();
      end
      if ($urandom_range(0, 19) == 0) begin
        for (int i = 0; i < 4; i++) begin
          f[i] = '0;
          t[i] = '0;
        end
      end
      queue_item(act, f, t, rand_blend());
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_percent) begin
        blend_item_t it;
        it = pending_items.pop_front();
        start <= 1'b1;
        in_action <= it.action;
        in_from_x <= it.from_c[0];
        in_from_y <= it.from_c[1];
        in_from_z <= it.from_c[2];
        in_from_w <= it.from_c[3];
        in_to_x <= it.to_c[0];
        in_to_y <= it.to_c[1];
        in_to_z <= it.to_c[2];
        in_to_w <= it.to_c[3];
        in_blend <= it.blend;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      blend_item_t it;
      it.action = in_action;
      it.from_c = '{in_from_x, in_from_y, in_from_z, in_from_w};
      it.to_c = '{in_to_x, in_to_y, in_to_z, in_to_w};
      it.blend = in_blend;
      expected_blends.push_back(predict_blend(it));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      logic [tcl_pkg::CW-1:0] got [4];
      blend_result_t exp_r;
      got = '{out_x, out_y, out_z, out_w};
      if (expected_blends.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h w=%h zl=%b", $time,
                 out_x, out_y, out_z, out_w, out_zero_length);
        error_count++;
      end else begin
        exp_r = expected_blends.pop_front();
        for (int i = 0; i < 4; i++)
          if (got[i] !== exp_r.comp[i]) begin
            $display("%0t: component %0d expected %h actual %h", $time, i,
                     exp_r.comp[i], got[i]);
            error_count++;
          end
        if (out_zero_length !== exp_r.zero_length) begin
          $display("%0t: zero_length expected %b actual %b", $time,
                   exp_r.zero_length, out_zero_length);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [tcl_pkg::CW-1:0] f [4];
    logic [tcl_pkg::CW-1:0] t [4];
    int phases [4];
    rst_n = 1'b0;
    start = 1'b0;
    in_action = 1'b0;
    {in_from_x, in_from_y, in_from_z, in_from_w} = '0;
    {in_to_x, in_to_y, in_to_z, in_to_w} = '0;
    in_blend = '0;
    idle_percent = 0;
    error_count = 0;
    phases = '{0, 56, 0, 36};
    for (int a = 0; a < 2; a++) begin
      f = '{32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'hffff_0000};
      t = '{32'h7fff_ffff, 32'h8000_0000, 32'hfffe_0000, 32'h0000_0001};
      queue_item(1'(a), f, t, '0);
      queue_item(1'(a), f, t, tcl_pkg::WW'(tcl_pkg::ONE));
      queue_item(1'(a), f, t, 17'h1_ffff);
      queue_item(1'(a), f, t, 17'h0_8000);
      queue_item(1'(a), f, t, 17'h0_0001);
      t = f;
      queue_item(1'(a), f, t, 17'h0_4000);
      f = '{32'h0, 32'h0, 32'h0, 32'h0};
      t = f;
      queue_item(1'(a), f, t, 17'h0_8000);
      f = '{32'h0000_0001, 32'h0, 32'h0, 32'hffff_ffff};
      t = '{32'hffff_ffff, 32'h0, 32'h0, 32'h0000_0001};
      queue_item(1'(a), f, t, 17'h0_8000);
      f = '{32'h0, 32'h0, 32'h0, 32'h0001_0000};
      t = '{32'h0001_0000, 32'h0, 32'h0, 32'h0};
      queue_item(1'(a), f, t, 17'h0_8000);
      f = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
      t = '{32'h5555_5555, 32'haaaa_aaaa, 32'h0, 32'h7fff_ffff};
      queue_item(1'(a), f, t, 17'h1_0001);
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int p = 0; p < 4; p++) begin
      idle_percent = phases[p];
      queue_random(410);
      while (pending_items.size() > 0) @(posedge clk);
    end
    idle_percent = 0;
    for (int c = 0; c < 5000 && (expected_blends.size() > 0 || start); c++)
      @(posedge clk);
    repeat (70) @(posedge clk);
    if (error_count == 0 && expected_blends.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (expected_blends.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_blends.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/tcl_pkg.sv
design/tcl_lerp.sv
design/tcl_scale.sv
design/tcl_sqrt.sv
design/tcl_div.sv
design/transform_component_lerp.sv
design/tcl_chk.sv
bench/transform_component_lerp_tb.sv
